// ----- rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants for the button press classifier: item structs,
// register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CIDX_W  = 8;
    localparam int unsigned SCNT_W  = 2;

    localparam logic [CIDX_W-1:0] REG_DEBOUNCE   = 8'd0;
    localparam logic [CIDX_W-1:0] REG_HOLD       = 8'd1;
    localparam logic [CIDX_W-1:0] REG_SHORT_MAX  = 8'd2;
    localparam logic [CIDX_W-1:0] REG_DOUBLE_GAP = 8'd3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd30;
    localparam logic [CFG_W-1:0] HOLD_RST       = 16'd1000;
    localparam logic [CFG_W-1:0] SHORT_MAX_RST  = 16'd350;
    localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = 16'd400;

    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              raw_lvl;
    } in_t;

    typedef struct packed {
        logic source_usb;
        logic science_mode;
        logic source_toggled;
        logic mode_toggled;
        logic debounced_lvl;
    } out_t;

endpackage

`default_nettype wire

// ----- rtl/button_press_classifier.sv -----
// Result path: input register, then result register; the state update is a single pass
// of compare logic. Throughput: one item per cycle while results are taken.
// Result register stalls on m_ready; input side keeps accepting while results are taken.
// Reset (aresetn low, synchronous): switch released, timestamps zero, source radio,
// science mode off, registers back to their defaults.
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounced push button with long-press source toggle and double-press
// science mode toggle, one poll per item.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bpc_pkg::in_t                  s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output bpc_pkg::out_t                      m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bpc_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [bpc_pkg::CFG_W-1:0]     cfg_data
);

    logic [bpc_pkg::CFG_W-1:0] debounce_reg;
    logic [bpc_pkg::CFG_W-1:0] hold_reg;
    logic [bpc_pkg::CFG_W-1:0] short_max_reg;
    logic [bpc_pkg::CFG_W-1:0] double_gap_reg;

    logic                  in_vld_reg;
    bpc_pkg::in_t          in_data_reg;
    logic                  out_vld_reg;
    bpc_pkg::out_t         out_data_reg;
    bpc_pkg::out_t         out_data_next;
    logic                  advance;

    logic                        source_sel_reg, source_sel_next;
    logic                        last_sample_reg, last_sample_next;
    logic                        stable_lvl_reg, stable_lvl_next;
    logic [bpc_pkg::TIME_W-1:0]  transition_time_reg, transition_time_next;
    logic [bpc_pkg::TIME_W-1:0]  press_time_reg, press_time_next;
    logic [bpc_pkg::TIME_W-1:0]  short_release_time_reg, short_release_time_next;
    logic                        long_done_reg, long_done_next;
    logic                        science_flag_reg, science_flag_next;
    logic [bpc_pkg::SCNT_W-1:0]  short_count_reg, short_count_next;

    logic [bpc_pkg::TIME_W-1:0]  now;
    logic                        lvl;
    logic [bpc_pkg::TIME_W-1:0]  deb_diff;
    logic [bpc_pkg::TIME_W-1:0]  dur;
    logic [bpc_pkg::TIME_W-1:0]  gap_diff;
    logic [bpc_pkg::TIME_W-1:0]  gap2_diff;
    logic [bpc_pkg::TIME_W-1:0]  hold_diff;
    logic [bpc_pkg::TIME_W-1:0]  debounce_ext;
    logic [bpc_pkg::TIME_W-1:0]  hold_ext;
    logic [bpc_pkg::TIME_W-1:0]  short_max_ext;
    logic [bpc_pkg::TIME_W-1:0]  gap_ext;
    logic                        src_pulse;
    logic                        mode_pulse;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_data_reg;

    assign debounce_ext  = {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}}, debounce_reg};
    assign hold_ext      = {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}}, hold_reg};
    assign short_max_ext = {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}}, short_max_reg};
    assign gap_ext       = {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}}, double_gap_reg};

    assign now = in_data_reg.now_ms;
    assign lvl = in_data_reg.raw_lvl;

    always_comb begin
        source_sel_next         = source_sel_reg;
        stable_lvl_next         = stable_lvl_reg;
        press_time_next         = press_time_reg;
        short_release_time_next = short_release_time_reg;
        long_done_next          = long_done_reg;
        science_flag_next       = science_flag_reg;
        short_count_next        = short_count_reg;
        src_pulse               = 1'b0;
        mode_pulse              = 1'b0;

        last_sample_next     = lvl;
        transition_time_next = (lvl != last_sample_reg) ? now : transition_time_reg;

        deb_diff = now - transition_time_next;
        dur      = now - press_time_reg;
        gap_diff = now - short_release_time_reg;

        if (stable_lvl_reg != last_sample_next && deb_diff >= debounce_ext) begin
            stable_lvl_next = last_sample_next;
            if (last_sample_next == bpc_pkg::LVL_PRESSED) begin
                press_time_next = now;
                long_done_next  = 1'b0;
            end else begin
                if (!long_done_reg) begin
                    if (dur != '0 && dur <= short_max_ext) begin
                        if (short_count_reg == '0 || gap_diff >= gap_ext) begin
                            short_count_next        = {{(bpc_pkg::SCNT_W-1){1'b0}}, 1'b1};
                            short_release_time_next = now;
                        end else begin
                            science_flag_next       = !science_flag_reg;
                            short_count_next        = '0;
                            short_release_time_next = '0;
                            mode_pulse              = 1'b1;
                        end
                    end else begin
                        short_count_next        = '0;
                        short_release_time_next = '0;
                    end
                end
                press_time_next = '0;
                long_done_next  = 1'b0;
            end
        end

        gap2_diff = now - short_release_time_next;
        if (short_count_next != '0 && gap2_diff >= gap_ext) begin
            short_count_next        = '0;
            short_release_time_next = '0;
        end

        hold_diff = now - press_time_next;
        if (stable_lvl_next == bpc_pkg::LVL_PRESSED && !long_done_next
                && hold_diff >= hold_ext) begin
            source_sel_next         = !source_sel_reg;
            src_pulse               = 1'b1;
            long_done_next          = 1'b1;
            short_count_next        = '0;
            short_release_time_next = '0;
        end

        out_data_next.source_usb     = source_sel_next;
        out_data_next.science_mode   = science_flag_next;
        out_data_next.source_toggled = src_pulse;
        out_data_next.mode_toggled   = mode_pulse;
        out_data_next.debounced_lvl  = stable_lvl_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= bpc_pkg::DEBOUNCE_RST;
            hold_reg       <= bpc_pkg::HOLD_RST;
            short_max_reg  <= bpc_pkg::SHORT_MAX_RST;
            double_gap_reg <= bpc_pkg::DOUBLE_GAP_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bpc_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                bpc_pkg::REG_HOLD:       hold_reg       <= cfg_data;
                bpc_pkg::REG_SHORT_MAX:  short_max_reg  <= cfg_data;
                bpc_pkg::REG_DOUBLE_GAP: double_gap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_sel_reg         <= 1'b0;
            last_sample_reg        <= bpc_pkg::LVL_RELEASED;
            stable_lvl_reg         <= bpc_pkg::LVL_RELEASED;
            transition_time_reg    <= '0;
            press_time_reg         <= '0;
            short_release_time_reg <= '0;
            long_done_reg          <= 1'b0;
            science_flag_reg       <= 1'b0;
            short_count_reg        <= '0;
        end else if (advance) begin
            source_sel_reg         <= source_sel_next;
            last_sample_reg        <= last_sample_next;
            stable_lvl_reg         <= stable_lvl_next;
            transition_time_reg    <= transition_time_next;
            press_time_reg         <= press_time_next;
            short_release_time_reg <= short_release_time_next;
            long_done_reg          <= long_done_next;
            science_flag_reg       <= science_flag_next;
            short_count_reg        <= short_count_next;
        end
    end

endmodule

`default_nettype wire
